// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the Lp-norm pooling RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define LPN_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define LPN_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define LPN_ASSERT(lbl, clk, rstn, prop, msg)
`define LPN_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ===== rtl/core/lpn_pkg.sv =====
// ----------------------------------------------------------------------------
// lpn_pkg
// Types and constants shared by the Lp-norm pooling modules.
// ----------------------------------------------------------------------------
package lpn_pkg;

  // Largest window size honored; larger sizes count as this one.
  localparam int MAX_WINDOW = 256;

  // Entries in the queue between the front and the back end.
  localparam int QUEUE_DEPTH = 4;

  // Smallest exponent, 1.0 in Q4.8.
  localparam logic [11:0] EXP_ONE = 12'd256;

  // Per-item attributes that travel with the magnitude.
  typedef struct packed {
    logic [11:0] p;
    logic [8:0]  n;
    logic        last;
  } lpn_attr_t;

  // Q2.30 constants 2^(2^-k), k = 1..16, each the truncated square root
  // of the one before.
  typedef logic [15:0][31:0] exp_tab_t;

  function automatic exp_tab_t exp2_consts();
    exp_tab_t    tab;
    logic [63:0] c;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    c = 64'd1 << 31;
    for (int k = 0; k < 16; k++) begin
      v = c << 30;
      r = 64'd0;
      b = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      c = r;
      tab[k] = c[31:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP2_CONST = exp2_consts();

endpackage

// ===== rtl/core/lpn_front.sv =====
// ----------------------------------------------------------------------------
// lpn_front
// Accepts window elements, takes the magnitude and clamps exponent and size.
// ----------------------------------------------------------------------------
module lpn_front import lpn_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_WIDTH-1:0] in_sample,
  input  logic [11:0]             in_exponent,
  input  logic [8:0]              in_window_size,
  input  logic                    in_last_of_window,
  output logic                    push,
  input  logic                    q_full,
  output logic [SAMPLE_WIDTH-1:0] push_mag,
  output lpn_attr_t               push_attr
);

  logic                    vld_r;
  logic [SAMPLE_WIDTH-1:0] mag_r;
  lpn_attr_t               attr_r;
  logic [SAMPLE_WIDTH-1:0] mag_nxt;
  lpn_attr_t               attr_nxt;

  assign push     = vld_r && !q_full;
  assign in_ready = !vld_r || !q_full;

  always_comb begin
    // Two's complement negation; the most negative code maps to 2^(W-1).
    mag_nxt = in_sample[SAMPLE_WIDTH-1] ? (~in_sample + 1'b1) : in_sample;
    attr_nxt.p = (in_exponent < EXP_ONE) ? EXP_ONE : in_exponent;
    if (in_window_size == 9'd0) begin
      attr_nxt.n = 9'd1;
    end else if (32'(in_window_size) > MAX_WINDOW) begin
      attr_nxt.n = 9'(MAX_WINDOW);
    end else begin
      attr_nxt.n = in_window_size;
    end
    attr_nxt.last = in_last_of_window;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld_r <= 1'b1;
    end else if (push) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mag_r  <= mag_nxt;
      attr_r <= attr_nxt;
    end
  end

  assign push_mag  = mag_r;
  assign push_attr = attr_r;

endmodule

// ===== rtl/core/lpn_queue.sv =====
// ----------------------------------------------------------------------------
// lpn_queue
// Small first-in first-out queue between the front and the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module lpn_queue import lpn_pkg::*; #(
  parameter int DW = 38
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output logic [DW-1:0] pop_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [DW-1:0] mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  `LPN_ASSERT_NEVER(a_q_no_overrun, clk, rst_n, push && !pop && full, "queue overrun")
  `LPN_ASSERT_NEVER(a_q_no_underrun, clk, rst_n, pop && !valid, "queue underrun")

endmodule

// ===== rtl/core/lpn_engine.sv =====
// ----------------------------------------------------------------------------
// lpn_engine
// Sequencer that accumulates |x|^p in the log domain and forms the Lp mean.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module lpn_engine import lpn_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int SUM_WIDTH    = 48
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  output logic                    q_pop,
  input  logic [SAMPLE_WIDTH-1:0] q_mag,
  input  lpn_attr_t               q_attr,
  input  logic                    norm_en,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [15:0]             out_pooled_value,
  output logic                    out_saturated
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_NORM = 9'b000000010,
    S_SQ   = 9'b000000100,
    S_MULP = 9'b000001000,
    S_EXP  = 9'b000010000,
    S_EXPF = 9'b000100000,
    S_ACC  = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  typedef enum logic [1:0] {
    LJ_MAG,
    LJ_SUM,
    LJ_CNT,
    LJ_MAX
  } log_job_t;

  localparam logic [65:0]        LIM_T  = (66'd1 << SUM_WIDTH) - 66'd1;
  localparam logic [65:0]        LIM_O  = 66'hFFFF;
  localparam logic signed [16:0] SOFF_T = -17'sd14;
  localparam logic signed [16:0] SOFF_O = -17'sd22;

  function automatic logic signed [7:0] job_fs(log_job_t j);
    case (j)
      LJ_MAG:  return 8'sd8;
      LJ_SUM:  return 8'sd16;
      LJ_CNT:  return 8'sd0;
      LJ_MAX:  return 8'sd8;
      default: return 8'sd0;
    endcase
  endfunction

  state_t   state_r, state_nxt;
  log_job_t job_r, job_nxt;

  logic [SUM_WIDTH-1:0]    sum_r, sum_nxt;
  logic [SAMPLE_WIDTH-1:0] max_r, max_nxt;
  logic                    ovf_r, ovf_nxt;
  logic                    out_valid_r;
  logic                    out_load;

  lpn_attr_t               attr_r, attr_nxt;
  logic [63:0]             nw_r, nw_nxt;
  logic [5:0]              cnt_r, cnt_nxt;
  logic [31:0]             m_r, m_nxt;
  logic [15:0]             fr_r, fr_nxt;
  logic [3:0]              it_r, it_nxt;
  logic signed [23:0]      lval_r, lval_nxt;
  logic signed [23:0]      lsum_r, lsum_nxt;
  logic signed [31:0]      e_r, e_nxt;
  logic                    fin_r, fin_nxt;
  logic [31:0]             f_r, f_nxt;
  logic [3:0]              k_r, k_nxt;
  logic [SUM_WIDTH-1:0]    t_r, t_nxt;
  logic                    tov_r, tov_nxt;
  logic [11:0]             rem_r, rem_nxt;
  logic [32:0]             quo_r, quo_nxt;
  logic [32:0]             num_r, num_nxt;
  logic                    dneg_r, dneg_nxt;
  logic [5:0]              dcnt_r, dcnt_nxt;
  logic [15:0]             pooled_r, pooled_nxt;
  logic                    sat_r, sat_nxt;

  // Shared 32x32 multiplier: squaring for log2, constant products for exp2.
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [32:0] sq;
  logic [31:0] m_new;
  logic [15:0] fr_new;
  logic signed [7:0]  lint;
  logic signed [23:0] log_val;
  logic signed [24:0] dval;
  logic [24:0]        dmag;
  logic signed [36:0] pl;
  logic [63:0]        fprod;
  logic [31:0]        f_new;
  logic               ebit;

  // Exp2 output stage.
  logic signed [15:0] ei;
  logic signed [16:0] s_amt;
  logic [65:0]        lim;
  logic [65:0]        fx;
  logic [65:0]        shl;
  logic [65:0]        rnd;
  logic [5:0]         rs;
  logic [65:0]        ev;
  logic               eov;

  // Divider step.
  logic [12:0] rem_sh;
  logic        ge;
  logic [11:0] rem_new;
  logic [32:0] quo_new;
  logic [31:0] rq;
  logic [31:0] rval;

  logic [SUM_WIDTH:0] acc;
  logic               out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    mul_a = (state_r == S_SQ) ? m_r : f_r;
    mul_b = (state_r == S_SQ) ? m_r : EXP2_CONST[k_r];
    mul_p = 64'(mul_a) * 64'(mul_b);
    sq     = mul_p[63:31];
    m_new  = sq[32] ? sq[32:1] : sq[31:0];
    fr_new = {fr_r[14:0], sq[32]};
    lint    = 8'sd63 - $signed({2'b00, cnt_r}) - job_fs(job_r);
    log_val = {lint, fr_new};
    dval = {lsum_r[23], lsum_r} - {log_val[23], log_val};
    dmag = dval[24] ? 25'(-dval) : 25'(dval);
    pl   = $signed({1'b0, attr_r.p}) * lval_r;
    fprod = mul_p + (64'd1 << 29);
    f_new = fprod[61:30];
    ebit  = e_r[4'd15 - k_r];
  end

  always_comb begin
    ei    = e_r[31:16];
    s_amt = $signed({ei[15], ei}) + (fin_r ? SOFF_O : SOFF_T);
    lim   = fin_r ? LIM_O : LIM_T;
    fx    = 66'(f_r);
    rs    = 6'(-s_amt);
    shl   = fx << s_amt[5:0];
    rnd   = (fx + (66'd1 << (rs - 6'd1))) >> rs;
    ev    = '0;
    eov   = 1'b0;
    if (!s_amt[16]) begin
      if (s_amt > 17'sd33 || shl > lim) begin
        ev  = lim;
        eov = 1'b1;
      end else begin
        ev = shl;
      end
    end else if (s_amt >= -17'sd40) begin
      if (rnd > lim) begin
        ev  = lim;
        eov = 1'b1;
      end else begin
        ev = rnd;
      end
    end
  end

  always_comb begin
    rem_sh  = {rem_r, num_r[32]};
    ge      = (rem_sh >= {1'b0, attr_r.p});
    rem_new = ge ? 12'(rem_sh - {1'b0, attr_r.p}) : rem_sh[11:0];
    quo_new = {quo_r[31:0], ge};
    rq      = quo_new[31:0];
    rval    = dneg_r ? -(rq + 32'(rem_new != 12'd0)) : rq;
    acc     = {1'b0, sum_r} + {1'b0, t_r};
  end

  always_comb begin
    state_nxt  = state_r;
    job_nxt    = job_r;
    sum_nxt    = sum_r;
    max_nxt    = max_r;
    ovf_nxt    = ovf_r;
    attr_nxt   = attr_r;
    nw_nxt     = nw_r;
    cnt_nxt    = cnt_r;
    m_nxt      = m_r;
    fr_nxt     = fr_r;
    it_nxt     = it_r;
    lval_nxt   = lval_r;
    lsum_nxt   = lsum_r;
    e_nxt      = e_r;
    fin_nxt    = fin_r;
    f_nxt      = f_r;
    k_nxt      = k_r;
    t_nxt      = t_r;
    tov_nxt    = tov_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    num_nxt    = num_r;
    dneg_nxt   = dneg_r;
    dcnt_nxt   = dcnt_r;
    pooled_nxt = pooled_r;
    sat_nxt    = sat_r;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          attr_nxt = q_attr;
          if (q_mag > max_r) begin
            max_nxt = q_mag;
          end
          if (q_mag != '0) begin
            nw_nxt    = 64'(q_mag);
            cnt_nxt   = '0;
            job_nxt   = LJ_MAG;
            state_nxt = S_NORM;
          end else if (q_attr.last) begin
            state_nxt = S_FIN;
          end
        end
      end
      S_NORM: begin
        if (nw_r[63:56] == 8'd0) begin
          nw_nxt  = {nw_r[55:0], 8'd0};
          cnt_nxt = cnt_r + 6'd8;
        end else if (!nw_r[63]) begin
          nw_nxt  = {nw_r[62:0], 1'b0};
          cnt_nxt = cnt_r + 6'd1;
        end else begin
          m_nxt     = nw_r[63:32];
          fr_nxt    = '0;
          it_nxt    = '0;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        m_nxt  = m_new;
        fr_nxt = fr_new;
        it_nxt = it_r + 4'd1;
        if (it_r == 4'd15) begin
          case (job_r)
            LJ_MAG: begin
              lval_nxt  = log_val;
              state_nxt = S_MULP;
            end
            LJ_SUM: begin
              lsum_nxt  = log_val;
              nw_nxt    = 64'(attr_r.n);
              cnt_nxt   = '0;
              job_nxt   = LJ_CNT;
              state_nxt = S_NORM;
            end
            LJ_CNT: begin
              num_nxt   = {dmag, 8'd0};
              dneg_nxt  = dval[24];
              rem_nxt   = '0;
              quo_nxt   = '0;
              dcnt_nxt  = '0;
              state_nxt = S_DIV;
            end
            LJ_MAX: begin
              e_nxt     = e_r - 32'(log_val);
              fin_nxt   = 1'b1;
              f_nxt     = 32'd1 << 30;
              k_nxt     = '0;
              state_nxt = S_EXP;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_MULP: begin
        e_nxt     = 32'(pl >>> 8);
        fin_nxt   = 1'b0;
        f_nxt     = 32'd1 << 30;
        k_nxt     = '0;
        state_nxt = S_EXP;
      end
      S_EXP: begin
        if (ebit) begin
          f_nxt = f_new;
        end
        k_nxt = k_r + 4'd1;
        if (k_r == 4'd15) begin
          state_nxt = S_EXPF;
        end
      end
      S_EXPF: begin
        if (!fin_r) begin
          t_nxt     = ev[SUM_WIDTH-1:0];
          tov_nxt   = eov;
          state_nxt = S_ACC;
        end else if (out_free) begin
          out_load   = 1'b1;
          pooled_nxt = ev[15:0];
          sat_nxt    = ovf_r | eov;
          sum_nxt    = '0;
          max_nxt    = '0;
          ovf_nxt    = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      S_ACC: begin
        if (acc[SUM_WIDTH]) begin
          sum_nxt = '1;
          ovf_nxt = 1'b1;
        end else begin
          sum_nxt = acc[SUM_WIDTH-1:0];
        end
        if (tov_r) begin
          ovf_nxt = 1'b1;
        end
        state_nxt = attr_r.last ? S_FIN : S_IDLE;
      end
      S_DIV: begin
        rem_nxt  = rem_new;
        quo_nxt  = quo_new;
        num_nxt  = {num_r[31:0], 1'b0};
        dcnt_nxt = dcnt_r + 6'd1;
        if (dcnt_r == 6'd32) begin
          e_nxt = rval;
          if (norm_en && max_r != '0) begin
            nw_nxt    = 64'(max_r);
            cnt_nxt   = '0;
            job_nxt   = LJ_MAX;
            state_nxt = S_NORM;
          end else begin
            fin_nxt   = 1'b1;
            f_nxt     = 32'd1 << 30;
            k_nxt     = '0;
            state_nxt = S_EXP;
          end
        end
      end
      S_FIN: begin
        if (sum_r == '0) begin
          if (out_free) begin
            out_load   = 1'b1;
            pooled_nxt = 16'd0;
            sat_nxt    = ovf_r;
            max_nxt    = '0;
            ovf_nxt    = 1'b0;
            state_nxt  = S_IDLE;
          end
        end else begin
          nw_nxt    = 64'(sum_r);
          cnt_nxt   = '0;
          job_nxt   = LJ_SUM;
          state_nxt = S_NORM;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sum_r       <= '0;
      max_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sum_r   <= sum_nxt;
      max_r   <= max_nxt;
      ovf_r   <= ovf_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    job_r    <= job_nxt;
    attr_r   <= attr_nxt;
    nw_r     <= nw_nxt;
    cnt_r    <= cnt_nxt;
    m_r      <= m_nxt;
    fr_r     <= fr_nxt;
    it_r     <= it_nxt;
    lval_r   <= lval_nxt;
    lsum_r   <= lsum_nxt;
    e_r      <= e_nxt;
    fin_r    <= fin_nxt;
    f_r      <= f_nxt;
    k_r      <= k_nxt;
    t_r      <= t_nxt;
    tov_r    <= tov_nxt;
    rem_r    <= rem_nxt;
    quo_r    <= quo_nxt;
    num_r    <= num_nxt;
    dneg_r   <= dneg_nxt;
    dcnt_r   <= dcnt_nxt;
    pooled_r <= pooled_nxt;
    sat_r    <= sat_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_pooled_value = pooled_r;
  assign out_saturated    = sat_r;

  `LPN_ASSERT(a_pop_when_idle, clk, rst_n, q_pop |-> (state_r == S_IDLE), "pop outside idle")
  `LPN_ASSERT(a_clear_after_result, clk, rst_n, out_load |=> (sum_r == '0 && max_r == '0 && !ovf_r), "window state not cleared")
  `LPN_ASSERT(a_result_source, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == S_EXPF || state_r == S_FIN), "result from wrong state")

endmodule

// ===== rtl/core/lp_norm_pool_window_unit.sv =====
// ----------------------------------------------------------------------------
// lp_norm_pool_window_unit: Lp-norm pooling of one window, one element a transfer.
// Element steps: a zero sample is popped and skipped; any other is popped, then goes through
// log2 normalize, 16 squarings, a scale, 16 exp2 steps, a round and an accumulate;
// one item at a time. Window end: a zero sum gives a zero result, else two log2 runs,
// a divider and one exp2, plus the log2 of the max when normalizing; log2 and exp2
// share the 32x32 multiplier. Reset (rst_n, synchronous, active low) clears the sum,
// the max, the queue and the normalize setting; there is no clearing pass.
// ----------------------------------------------------------------------------
//
// The front end registers each accepted transfer, takes the magnitude of the
// sample and clamps exponent and window size. A four-entry queue decouples it
// from the back end, so elements keep flowing in while the sequencer works on
// an earlier one or while a finished result waits in the output register.
//
// The back end works in base-2 logarithms: each nonzero element becomes
// 2^(p*log2|x|), which is added into a saturating sum. On the last element of
// a window the root (sum/N)^(1/p) is formed as 2^((log2 sum - log2 N)/p),
// optionally divided by the window's largest magnitude, and presented on the
// result channel in Q8.8 with a saturation flag.
//
// The configuration register is a single bit written whenever
// cfg_write_enable is high; it is sampled at the end of each window.
module lp_norm_pool_window_unit import lpn_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int SUM_WIDTH    = 48
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [SAMPLE_WIDTH-1:0] in_sample,
  input  logic [11:0]             in_exponent,
  input  logic [8:0]              in_window_size,
  input  logic                    in_last_of_window,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [15:0]             out_pooled_value,
  output logic                    out_saturated,
  input  logic                    cfg_write_enable,
  input  logic                    cfg_write_data
);

  localparam int QW = SAMPLE_WIDTH + $bits(lpn_attr_t);

  // Normalize setting; the user must write it only between windows, the block does not enforce this.
  logic norm_en_r;

  logic                    push;
  logic                    q_full;
  logic [SAMPLE_WIDTH-1:0] push_mag;
  lpn_attr_t               push_attr;
  logic                    q_valid;
  logic                    q_pop;
  logic [QW-1:0]           q_data;
  logic [SAMPLE_WIDTH-1:0] q_mag;
  lpn_attr_t               q_attr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_en_r <= 1'b0;
    end else if (cfg_write_enable) begin
      norm_en_r <= cfg_write_data;
    end
  end

  // Front end: input handshake, magnitude and clamping.
  lpn_front #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .in_exponent       (in_exponent),
    .in_window_size    (in_window_size),
    .in_last_of_window (in_last_of_window),
    .push              (push),
    .q_full            (q_full),
    .push_mag          (push_mag),
    .push_attr         (push_attr)
  );

  // Queue that lets the front and back stall independently.
  lpn_queue #(
    .DW (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_mag, push_attr}),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_data)
  );

  assign q_mag  = q_data[QW-1 -: SAMPLE_WIDTH];
  assign q_attr = q_data[$bits(lpn_attr_t)-1:0];

  // Back end: log-domain accumulation, root and output register.
  lpn_engine #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .SUM_WIDTH    (SUM_WIDTH)
  ) u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_mag            (q_mag),
    .q_attr           (q_attr),
    .norm_en          (norm_en_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pooled_value (out_pooled_value),
    .out_saturated    (out_saturated)
  );

endmodule
